### hw/rtl/polygon_scanline_edge_walker_defines.svh
// assertion macros shared by the edge walker modules
`ifndef POLYGON_SCANLINE_EDGE_WALKER_DEFINES_SVH
`define POLYGON_SCANLINE_EDGE_WALKER_DEFINES_SVH

// same-cycle implication
`define PSEW_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PSEW_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/psew_pkg.sv
package psew_pkg;

	localparam int COORD_W = 16;
	localparam int CFG_W = 13;
	localparam int CFG_IDX_W = 2;
	localparam int SPAN_W = 12;
	localparam int MAX_DIM_DEFAULT = 4096;

	localparam logic [CFG_W-1:0] FRAME_WIDTH_RESET = 13'd320;
	localparam logic [CFG_W-1:0] FRAME_HEIGHT_RESET = 13'd200;

	localparam int Q_W = 15;
	localparam logic [Q_W-1:0] DIVIDEND = 15'h4000;
	localparam int DIV_STEPS = Q_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	localparam logic [COORD_W-1:0] FRAC_LEFT = 16'h7FFF;
	localparam logic [COORD_W-1:0] FRAC_RIGHT = 16'h8000;

	typedef enum logic [1:0] {
		KIND_START   = 2'd0,
		KIND_PAIR    = 2'd1,
		KIND_ADVANCE = 2'd2
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_WIDTH  = 2'd0,
		REG_FRAME_HEIGHT = 2'd1
	} cfg_reg_t;

	typedef struct packed {
		logic exec;
		logic div_start;
		logic div_right;
		logic mul_step;
		logic mul_right;
		logic pair_finish;
	} cmd_t;

	typedef struct packed {
		logic  hold_valid;
		kind_t kind;
		logic  walk_ended;
		logic  out_free;
		logic  div_done;
	} status_t;

endpackage

### hw/rtl/psew_div.sv
module psew_div (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic [psew_pkg::COORD_W-1:0]       den,
	output logic [psew_pkg::Q_W-1:0]           quot,
	output logic                               done
);

	logic [psew_pkg::Q_W-1:0]       num_q;
	logic [psew_pkg::COORD_W-1:0]   rem_q;
	logic [psew_pkg::COORD_W-1:0]   den_q;
	logic [psew_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                           busy_q;
	logic                           done_q;
	logic [psew_pkg::COORD_W:0]     trial;
	logic                           fits;

	assign trial = {rem_q, num_q[psew_pkg::Q_W-1]};
	assign fits = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q <= '0;
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + psew_pkg::DIV_CNT_W'(1);
			if (cnt_q == psew_pkg::DIV_CNT_W'(psew_pkg::DIV_STEPS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= psew_pkg::DIVIDEND;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= psew_pkg::COORD_W'(trial - {1'b0, den_q});
				num_q <= {num_q[psew_pkg::Q_W-2:0], 1'b1};
			end else begin
				rem_q <= trial[psew_pkg::COORD_W-1:0];
				num_q <= {num_q[psew_pkg::Q_W-2:0], 1'b0};
			end
		end
	end

	assign quot = num_q;
	assign done = done_q;

endmodule

### hw/rtl/psew_datapath.sv
`include "polygon_scanline_edge_walker_defines.svh"

module psew_datapath #(
	parameter int MAX_DIM = psew_pkg::MAX_DIM_DEFAULT
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [psew_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [psew_pkg::CFG_W-1:0]           cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [1:0]                           kind,
	input  logic signed [psew_pkg::COORD_W-1:0]  left_x,
	input  logic signed [psew_pkg::COORD_W-1:0]  left_y,
	input  logic signed [psew_pkg::COORD_W-1:0]  right_x,
	input  logic signed [psew_pkg::COORD_W-1:0]  right_y,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic                                 span_valid,
	output logic [psew_pkg::SPAN_W-1:0]          span_left,
	output logic [psew_pkg::SPAN_W-1:0]          span_right,
	output logic [psew_pkg::SPAN_W-1:0]          span_row,
	output logic                                 segment_done,
	output logic                                 polygon_done,
	input  psew_pkg::cmd_t                       cmd,
	output psew_pkg::status_t                    status
);

	localparam int CW = psew_pkg::COORD_W;
	localparam int DIM_W = $clog2(MAX_DIM + 1);

	// configuration
	logic [psew_pkg::CFG_W-1:0] frame_width_q;
	logic [psew_pkg::CFG_W-1:0] frame_height_q;

	// input hold
	logic          hold_valid_q;
	logic [1:0]    hold_kind_q;
	logic [CW-1:0] hold_lx_q;
	logic [CW-1:0] hold_ly_q;
	logic [CW-1:0] hold_rx_q;
	logic [CW-1:0] hold_ry_q;

	// walk state
	logic [2*CW-1:0] left_accum_q;
	logic [2*CW-1:0] right_accum_q;
	logic [2*CW-1:0] left_step_q;
	logic [2*CW-1:0] right_step_q;
	logic [CW-1:0]   current_row_q;
	logic [CW-1:0]   rows_left_q;
	logic [2*CW-1:0] prev_left_q;
	logic [2*CW-1:0] prev_right_q;
	logic            walk_ended_q;

	// step computation
	logic signed [CW:0]         dx_q;
	logic [CW-1:0]              cnt_q;
	logic [CW-1:0]              dy_sel;
	logic [CW-1:0]              den;
	logic signed [CW:0]         dx_sel;
	logic [psew_pkg::Q_W-1:0]   quot;
	logic                       div_done;
	logic [2*CW-1:0]            dx_ext;
	logic [2*CW-1:0]            prod;
	logic [2*CW-1:0]            step_new;

	// output register
	logic                          out_valid_q;
	logic                          span_valid_q;
	logic [psew_pkg::SPAN_W-1:0]   span_left_q;
	logic [psew_pkg::SPAN_W-1:0]   span_right_q;
	logic [psew_pkg::SPAN_W-1:0]   span_row_q;
	logic                          segment_done_q;
	logic                          polygon_done_q;

	logic out_free;
	logic consume;
	logic accept;
	logic result_load;

	// frame limits
	logic [31:0]       fw32;
	logic [31:0]       fh32;
	logic [DIM_W-1:0]  w;
	logic [DIM_W-1:0]  h;
	logic signed [CW:0] w_x;
	logic signed [CW:0] h_x;

	// span evaluation
	logic signed [CW:0] x1_x;
	logic signed [CW:0] x2_x;
	logic signed [CW:0] row_x;
	logic [CW-1:0]      row_inc;
	logic signed [CW:0] row_inc_x;
	logic [CW-1:0]      x1c;
	logic [CW-1:0]      x2c;
	logic [CW-1:0]      span_lo;
	logic [CW-1:0]      span_hi;
	logic [2*CW-1:0]    left_frac;
	logic [2*CW-1:0]    right_frac;

	// next values
	logic [2*CW-1:0] n_left_accum;
	logic [2*CW-1:0] n_right_accum;
	logic [CW-1:0]   n_current_row;
	logic [CW-1:0]   n_rows_left;
	logic [2*CW-1:0] n_prev_left;
	logic [2*CW-1:0] n_prev_right;
	logic            n_walk_ended;
	logic            o_valid;
	logic [psew_pkg::SPAN_W-1:0] o_left;
	logic [psew_pkg::SPAN_W-1:0] o_right;
	logic [psew_pkg::SPAN_W-1:0] o_row;

	assign out_free = !out_valid_q || !out_stall;
	assign consume = cmd.exec || cmd.pair_finish;
	assign result_load = consume;
	assign in_stall = hold_valid_q && !consume;
	assign accept = in_valid && !in_stall;

	assign fw32 = 32'(frame_width_q);
	assign fh32 = 32'(frame_height_q);
	assign w = (fw32 == 32'd0) ? DIM_W'(1) :
		(fw32 > 32'(MAX_DIM)) ? DIM_W'(MAX_DIM) : DIM_W'(fw32);
	assign h = (fh32 == 32'd0) ? DIM_W'(1) :
		(fh32 > 32'(MAX_DIM)) ? DIM_W'(MAX_DIM) : DIM_W'(fh32);
	assign w_x = $signed((CW+1)'(w));
	assign h_x = $signed((CW+1)'(h));

	assign x1_x = $signed({left_accum_q[2*CW-1], left_accum_q[2*CW-1:CW]});
	assign x2_x = $signed({right_accum_q[2*CW-1], right_accum_q[2*CW-1:CW]});
	assign row_x = $signed({current_row_q[CW-1], current_row_q});
	assign row_inc = current_row_q + CW'(1);
	assign row_inc_x = $signed({row_inc[CW-1], row_inc});
	assign x1c = x1_x[CW] ? '0 : left_accum_q[2*CW-1:CW];
	assign x2c = (x2_x >= w_x) ? CW'(w - DIM_W'(1)) : right_accum_q[2*CW-1:CW];
	assign span_lo = (x1c < x2c) ? x1c : x2c;
	assign span_hi = (x1c < x2c) ? x2c : x1c;
	assign left_frac = {left_accum_q[2*CW-1:CW], psew_pkg::FRAC_LEFT};
	assign right_frac = {right_accum_q[2*CW-1:CW], psew_pkg::FRAC_RIGHT};

	// edge deltas for the divider and multiplier
	assign dy_sel = cmd.div_right ? (hold_ry_q - prev_right_q[CW-1:0])
		: (hold_ly_q - prev_left_q[CW-1:0]);
	assign den = (dy_sel <= CW'(1)) ? CW'(1) : dy_sel;
	assign dx_sel = cmd.div_right
		? ($signed({hold_rx_q[CW-1], hold_rx_q}) - $signed({prev_right_q[2*CW-1],
			prev_right_q[2*CW-1:CW]}))
		: ($signed({hold_lx_q[CW-1], hold_lx_q}) - $signed({prev_left_q[2*CW-1],
			prev_left_q[2*CW-1:CW]}));
	assign dx_ext = {{(CW-1){dx_q[CW]}}, dx_q};
	assign prod = dx_ext * (2*CW)'(quot);
	assign step_new = {prod[2*CW-3:0], 2'b00};

	psew_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.den    (den),
		.quot   (quot),
		.done   (div_done)
	);

	always_comb begin
		n_left_accum = left_accum_q;
		n_right_accum = right_accum_q;
		n_current_row = current_row_q;
		n_rows_left = rows_left_q;
		n_prev_left = prev_left_q;
		n_prev_right = prev_right_q;
		n_walk_ended = walk_ended_q;
		o_valid = 1'b0;
		o_left = '0;
		o_right = '0;
		o_row = '0;
		if (cmd.exec) begin
			unique case (psew_pkg::kind_t'(hold_kind_q))
				psew_pkg::KIND_START: begin
					n_prev_left = {hold_lx_q, hold_ly_q};
					n_prev_right = {hold_rx_q, hold_ry_q};
					n_left_accum = {hold_lx_q, {CW{1'b0}}};
					n_right_accum = {hold_rx_q, {CW{1'b0}}};
					n_current_row = ($signed(hold_ly_q) < $signed(hold_ry_q))
						? hold_ly_q : hold_ry_q;
					n_rows_left = '0;
					n_walk_ended = 1'b0;
				end
				psew_pkg::KIND_ADVANCE: begin
					if (!walk_ended_q && rows_left_q != '0) begin
						if (row_x >= h_x) begin
							n_walk_ended = 1'b1;
							n_rows_left = '0;
						end else begin
							if (!current_row_q[CW-1] && x1_x < w_x && !x2_x[CW]) begin
								o_valid = 1'b1;
								o_left = span_lo[psew_pkg::SPAN_W-1:0];
								o_right = span_hi[psew_pkg::SPAN_W-1:0];
								o_row = current_row_q[psew_pkg::SPAN_W-1:0];
							end
							n_left_accum = left_accum_q + left_step_q;
							n_right_accum = right_accum_q + right_step_q;
							n_current_row = row_inc;
							n_rows_left = rows_left_q - CW'(1);
							if (row_inc_x >= h_x) begin
								n_walk_ended = 1'b1;
								n_rows_left = '0;
							end
						end
					end
				end
				default: begin
				end
			endcase
		end else if (cmd.pair_finish) begin
			n_prev_left = {hold_lx_q, hold_ly_q};
			n_prev_right = {hold_rx_q, hold_ry_q};
			n_left_accum = (cnt_q == '0) ? left_frac + left_step_q : left_frac;
			n_right_accum = (cnt_q == '0) ? right_frac + right_step_q : right_frac;
			n_rows_left = cnt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q <= psew_pkg::FRAME_WIDTH_RESET;
			frame_height_q <= psew_pkg::FRAME_HEIGHT_RESET;
		end else if (cfg_we) begin
			unique case (psew_pkg::cfg_reg_t'(cfg_index))
				psew_pkg::REG_FRAME_WIDTH: frame_width_q <= cfg_data;
				psew_pkg::REG_FRAME_HEIGHT: frame_height_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
			left_accum_q <= '0;
			right_accum_q <= '0;
			left_step_q <= '0;
			right_step_q <= '0;
			current_row_q <= '0;
			rows_left_q <= '0;
			prev_left_q <= '0;
			prev_right_q <= '0;
			walk_ended_q <= 1'b0;
		end else begin
			if (accept) begin
				hold_valid_q <= 1'b1;
			end else if (consume) begin
				hold_valid_q <= 1'b0;
			end
			if (result_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.mul_step) begin
				if (cmd.mul_right) begin
					right_step_q <= step_new;
				end else begin
					left_step_q <= step_new;
				end
			end
			left_accum_q <= n_left_accum;
			right_accum_q <= n_right_accum;
			current_row_q <= n_current_row;
			rows_left_q <= n_rows_left;
			prev_left_q <= n_prev_left;
			prev_right_q <= n_prev_right;
			walk_ended_q <= n_walk_ended;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			hold_kind_q <= kind;
			hold_lx_q <= left_x;
			hold_ly_q <= left_y;
			hold_rx_q <= right_x;
			hold_ry_q <= right_y;
		end
		if (cmd.div_start) begin
			dx_q <= dx_sel;
			if (cmd.div_right) begin
				cnt_q <= dy_sel;
			end
		end
		if (result_load) begin
			span_valid_q <= o_valid;
			span_left_q <= o_left;
			span_right_q <= o_right;
			span_row_q <= o_row;
			segment_done_q <= (n_rows_left == '0);
			polygon_done_q <= n_walk_ended;
		end
	end

	assign out_valid = out_valid_q;
	assign span_valid = span_valid_q;
	assign span_left = span_left_q;
	assign span_right = span_right_q;
	assign span_row = span_row_q;
	assign segment_done = segment_done_q;
	assign polygon_done = polygon_done_q;

	assign status.hold_valid = hold_valid_q;
	assign status.kind = psew_pkg::kind_t'(hold_kind_q);
	assign status.walk_ended = walk_ended_q;
	assign status.out_free = out_free;
	assign status.div_done = div_done;

	`PSEW_ASSERT_IMPL(a_ended_no_rows, walk_ended_q, rows_left_q == '0, "rows left after walk end")
	`PSEW_ASSERT_IMPL(a_consume_has_beat, consume, hold_valid_q && out_free, "result without held beat")

endmodule

### hw/rtl/psew_ctrl.sv
`include "polygon_scanline_edge_walker_defines.svh"

module psew_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  psew_pkg::status_t status,
	output psew_pkg::cmd_t    cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV_L,
		ST_MUL_L,
		ST_DIV_R,
		ST_MUL_R,
		ST_FIN
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (status.hold_valid) begin
					if (status.kind == psew_pkg::KIND_PAIR && !status.walk_ended) begin
						cmd.div_start = 1'b1;
						state_d = ST_DIV_L;
					end else if (status.out_free) begin
						cmd.exec = 1'b1;
					end
				end
			end
			ST_DIV_L: begin
				if (status.div_done) begin
					state_d = ST_MUL_L;
				end
			end
			ST_MUL_L: begin
				cmd.mul_step = 1'b1;
				cmd.div_start = 1'b1;
				cmd.div_right = 1'b1;
				state_d = ST_DIV_R;
			end
			ST_DIV_R: begin
				if (status.div_done) begin
					state_d = ST_MUL_R;
				end
			end
			ST_MUL_R: begin
				cmd.mul_step = 1'b1;
				cmd.mul_right = 1'b1;
				state_d = ST_FIN;
			end
			ST_FIN: begin
				if (status.out_free) begin
					cmd.pair_finish = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	`PSEW_ASSERT_IMPL(a_result_slot, cmd.exec || cmd.pair_finish, status.out_free, "result with no free slot")
	`PSEW_ASSERT_NEXT(a_div_wait, state_q == ST_DIV_L && !status.div_done, state_q == ST_DIV_L, "left divide left early")
	`PSEW_ASSERT_IMPL(a_div_pairs_only, cmd.div_start && state_q == ST_IDLE, status.kind == psew_pkg::KIND_PAIR && !status.walk_ended, "divide for non-pair beat")

endmodule

### hw/rtl/polygon_scanline_edge_walker.sv
// start, advance and other short beats: result through the hold and output registers, one
// per cycle while the output is not stalled; vertex pair: the shared one-bit-per-cycle
// 15-step divider run once per edge, then a multiply per edge
// an input beat is taken into a hold register while the previous result waits
// reset (arst_n low, asynchronous): walk state zero, frame 320 by 200, no clearing pass
module polygon_scanline_edge_walker #(
	parameter int MAX_DIM = psew_pkg::MAX_DIM_DEFAULT
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [psew_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [psew_pkg::CFG_W-1:0]           cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [1:0]                           kind,
	input  logic signed [psew_pkg::COORD_W-1:0]  left_x,
	input  logic signed [psew_pkg::COORD_W-1:0]  left_y,
	input  logic signed [psew_pkg::COORD_W-1:0]  right_x,
	input  logic signed [psew_pkg::COORD_W-1:0]  right_y,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic                                 span_valid,
	output logic [psew_pkg::SPAN_W-1:0]          span_left,
	output logic [psew_pkg::SPAN_W-1:0]          span_right,
	output logic [psew_pkg::SPAN_W-1:0]          span_row,
	output logic                                 segment_done,
	output logic                                 polygon_done
);

	psew_pkg::cmd_t    cmd;
	psew_pkg::status_t status;

	psew_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.cmd    (cmd)
	);

	psew_datapath #(
		.MAX_DIM (MAX_DIM)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.kind         (kind),
		.left_x       (left_x),
		.left_y       (left_y),
		.right_x      (right_x),
		.right_y      (right_y),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.span_valid   (span_valid),
		.span_left    (span_left),
		.span_right   (span_right),
		.span_row     (span_row),
		.segment_done (segment_done),
		.polygon_done (polygon_done),
		.cmd          (cmd),
		.status       (status)
	);

endmodule
